[rtl/core/quaternion_vector_rotate_assert.svh]
// Assertion macros used by the quaternion rotator checker.
`ifndef QUATERNION_VECTOR_ROTATE_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define QVR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("qvr assertion failed");

// Next-cycle implication, disabled while in reset.
`define QVR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("qvr assertion failed");

`endif

[rtl/core/qvr_pkg.sv]
// Types, widths and register codes for the quaternion vector rotator.
package qvr_pkg;

    localparam int VECTOR_WIDTH = 24;
    localparam int QUAT_WIDTH   = 16;
    localparam int FRAC_BITS    = QUAT_WIDTH - 2;
    localparam int SHIFT_BITS   = 2 * FRAC_BITS;
    localparam int PROD_W       = 2 * QUAT_WIDTH;
    localparam int COEF_W       = PROD_W + 2;
    localparam int TERM_W       = COEF_W + VECTOR_WIDTH;
    localparam int SUM_W        = TERM_W + 2;
    localparam int NSTAGE       = 5;
    localparam int CFG_IDX_W    = 3;

    typedef logic signed [VECTOR_WIDTH-1:0] vec_t;
    typedef logic signed [QUAT_WIDTH-1:0]   quat_t;
    typedef logic signed [PROD_W-1:0]       prod_t;
    typedef logic signed [COEF_W-1:0]       coef_t;
    typedef logic signed [TERM_W-1:0]       term_t;
    typedef logic signed [SUM_W-1:0]        sum_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUAT_X = 3'd0,
        REG_QUAT_Y = 3'd1,
        REG_QUAT_Z = 3'd2,
        REG_QUAT_W = 3'd3
    } cfg_idx_t;

    localparam quat_t QUAT_ONE = QUAT_WIDTH'(1) << FRAC_BITS;
    localparam vec_t  VEC_MAX  = {1'b0, {(VECTOR_WIDTH-1){1'b1}}};
    localparam vec_t  VEC_MIN  = {1'b1, {(VECTOR_WIDTH-1){1'b0}}};
    localparam sum_t  ROUND_HALF = SUM_W'(1) << (SHIFT_BITS - 1);

endpackage

[rtl/core/qvr_round_sat.sv]
// Drops the fraction bits of a pre-rounded sum and clamps it to the vector range.
module qvr_round_sat
(
    input  qvr_pkg::sum_t acc,
    output qvr_pkg::vec_t value,
    output logic          sat
);
    import qvr_pkg::*;

    localparam int HI = SHIFT_BITS + VECTOR_WIDTH - 1;

    logic [SUM_W-1-HI:0] upper;
    logic                fits;

    // bits above the kept field must all copy the sign
    assign upper = acc[SUM_W-1:HI];
    assign fits  = (&upper) | (~|upper);
    assign sat   = ~fits;

    always_comb
    begin
        if (fits)
        begin
            value = acc[HI:SHIFT_BITS];
        end
        else if (acc[SUM_W-1])
        begin
            value = VEC_MIN;
        end
        else
        begin
            value = VEC_MAX;
        end
    end

endmodule

[rtl/core/quaternion_vector_rotate.sv]
// Quaternion vector rotator: five-stage pipeline, quaternion held in config registers.
//
//  channel  direction  handshake             word
//  in       sink       in_valid / in_stall   kind, vec_x, vec_y, vec_z
//  out      source     out_valid / out_stall out_x, out_y, out_z, saturated
//  cfg      sink       cfg_we                cfg_index, cfg_data
//
// One word per cycle sustained while out_stall is low.
// Stages: quaternion products, rotation matrix, matrix x vector, row sum with
// rounding half, shift and clamp into the output register.
// Each stage holds its word while the next one is full and stalled; in_stall
// rises only when every stage is occupied and out_stall is high.
// Reset empties the pipeline and loads the identity quaternion.
module quaternion_vector_rotate
(
    input  logic                clk,
    input  logic                rst_n,
    // config
    input  logic                cfg_we,
    input  qvr_pkg::cfg_idx_t   cfg_index,
    input  qvr_pkg::quat_t      cfg_data,
    // input words
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                kind,
    input  qvr_pkg::vec_t       vec_x,
    input  qvr_pkg::vec_t       vec_y,
    input  qvr_pkg::vec_t       vec_z,
    // result words
    output logic                out_valid,
    input  logic                out_stall,
    output qvr_pkg::vec_t       out_x,
    output qvr_pkg::vec_t       out_y,
    output qvr_pkg::vec_t       out_z,
    output logic                saturated
);
    import qvr_pkg::*;

    // ---------------------------------------------------------------
    // Quaternion registers. The user must write them only while the pipe
    // is empty (the block does not enforce this), so stage 1 can read them directly.
    // ---------------------------------------------------------------
    quat_t quat_x_reg, quat_y_reg, quat_z_reg, quat_w_reg;
    quat_t quat_x_next, quat_y_next, quat_z_next, quat_w_next;

    always_comb
    begin
        quat_x_next = quat_x_reg;
        quat_y_next = quat_y_reg;
        quat_z_next = quat_z_reg;
        quat_w_next = quat_w_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_QUAT_X: quat_x_next = cfg_data;
                REG_QUAT_Y: quat_y_next = cfg_data;
                REG_QUAT_Z: quat_z_next = cfg_data;
                REG_QUAT_W: quat_w_next = cfg_data;
                default:    ; // indexes beyond the register file are dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_x_reg <= '0;
            quat_y_reg <= '0;
            quat_z_reg <= '0;
            quat_w_reg <= QUAT_ONE;
        end
        else
        begin
            quat_x_reg <= quat_x_next;
            quat_y_reg <= quat_y_next;
            quat_z_reg <= quat_z_next;
            quat_w_reg <= quat_w_next;
        end
    end

    // ---------------------------------------------------------------
    // Pipeline flow control: a stage moves when it is empty or the
    // stage after it moves. Last stage is the output register.
    // ---------------------------------------------------------------
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] adv;

    always_comb
    begin
        adv[NSTAGE-1] = ~valid_reg[NSTAGE-1] | ~out_stall;
        for (int k = NSTAGE - 2; k >= 0; k--)
        begin
            adv[k] = ~valid_reg[k] | adv[k+1];
        end
    end

    assign in_stall  = ~adv[0];
    assign out_valid = valid_reg[NSTAGE-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTAGE; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: the ten quaternion pair products
    // ---------------------------------------------------------------
    prod_t ww_reg, xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    vec_t  s1_vec_reg [3];
    logic  s1_kind_reg;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            ww_reg <= PROD_W'(quat_w_reg) * PROD_W'(quat_w_reg);
            xx_reg <= PROD_W'(quat_x_reg) * PROD_W'(quat_x_reg);
            yy_reg <= PROD_W'(quat_y_reg) * PROD_W'(quat_y_reg);
            zz_reg <= PROD_W'(quat_z_reg) * PROD_W'(quat_z_reg);
            xy_reg <= PROD_W'(quat_x_reg) * PROD_W'(quat_y_reg);
            xz_reg <= PROD_W'(quat_x_reg) * PROD_W'(quat_z_reg);
            yz_reg <= PROD_W'(quat_y_reg) * PROD_W'(quat_z_reg);
            wx_reg <= PROD_W'(quat_w_reg) * PROD_W'(quat_x_reg);
            wy_reg <= PROD_W'(quat_w_reg) * PROD_W'(quat_y_reg);
            wz_reg <= PROD_W'(quat_w_reg) * PROD_W'(quat_z_reg);
            s1_vec_reg[0] <= vec_x;
            s1_vec_reg[1] <= vec_y;
            s1_vec_reg[2] <= vec_z;
            s1_kind_reg   <= kind;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: rotation matrix, row-major. kind flips the sign of the
    // 2w*u cross terms (q* v q is the transpose).
    // ---------------------------------------------------------------
    coef_t ww_c, xx_c, yy_c, zz_c;
    coef_t xy2, xz2, yz2, wx2, wy2, wz2;
    coef_t wx_s, wy_s, wz_s;
    coef_t coef_next [9];
    coef_t coef_reg  [9];
    vec_t  s2_vec_reg [3];

    always_comb
    begin
        ww_c = COEF_W'(ww_reg);
        xx_c = COEF_W'(xx_reg);
        yy_c = COEF_W'(yy_reg);
        zz_c = COEF_W'(zz_reg);
        xy2  = COEF_W'(xy_reg) <<< 1;
        xz2  = COEF_W'(xz_reg) <<< 1;
        yz2  = COEF_W'(yz_reg) <<< 1;
        wx2  = COEF_W'(wx_reg) <<< 1;
        wy2  = COEF_W'(wy_reg) <<< 1;
        wz2  = COEF_W'(wz_reg) <<< 1;
        // signed cross term, positive for q v q*
        wx_s = s1_kind_reg ? -wx2 : wx2;
        wy_s = s1_kind_reg ? -wy2 : wy2;
        wz_s = s1_kind_reg ? -wz2 : wz2;

        coef_next[0] = ww_c + xx_c - yy_c - zz_c;
        coef_next[1] = xy2 - wz_s;
        coef_next[2] = xz2 + wy_s;
        coef_next[3] = xy2 + wz_s;
        coef_next[4] = ww_c - xx_c + yy_c - zz_c;
        coef_next[5] = yz2 - wx_s;
        coef_next[6] = xz2 - wy_s;
        coef_next[7] = yz2 + wx_s;
        coef_next[8] = ww_c - xx_c - yy_c + zz_c;
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            coef_reg   <= coef_next;
            s2_vec_reg <= s1_vec_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: nine coefficient x component products
    // ---------------------------------------------------------------
    term_t term_reg [9];

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    term_reg[3*r+c] <= TERM_W'(coef_reg[3*r+c]) * TERM_W'(s2_vec_reg[c]);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: row sums plus half an output LSB (ties go up)
    // ---------------------------------------------------------------
    sum_t sum_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            for (int r = 0; r < 3; r++)
            begin
                sum_reg[r] <= SUM_W'(term_reg[3*r]) + SUM_W'(term_reg[3*r+1])
                            + SUM_W'(term_reg[3*r+2]) + ROUND_HALF;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: shift out the fraction, clamp, output register
    // ---------------------------------------------------------------
    vec_t rs_value [3];
    logic [2:0] rs_sat;

    for (genvar g = 0; g < 3; g++)
    begin : g_round
        qvr_round_sat u_round_sat
        (
            .acc   (sum_reg[g]),
            .value (rs_value[g]),
            .sat   (rs_sat[g])
        );
    end

    vec_t out_x_reg, out_y_reg, out_z_reg;
    logic saturated_reg;

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            out_x_reg     <= rs_value[0];
            out_y_reg     <= rs_value[1];
            out_z_reg     <= rs_value[2];
            saturated_reg <= |rs_sat;
        end
    end

    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign saturated = saturated_reg;

endmodule

[rtl/core/qvr_checker.sv]
// Port-level checks for the quaternion rotator, bound to the top level.
`include "quaternion_vector_rotate_assert.svh"

module qvr_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input qvr_pkg::vec_t     out_x,
    input qvr_pkg::vec_t     out_y,
    input qvr_pkg::vec_t     out_z,
    input logic              saturated
);
    import qvr_pkg::*;

    // a stalled result word holds
    `QVR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(saturated))

    // with the output register empty the pipe always has room
    `QVR_ASSERT_NOW(a_room_when_empty, clk, rst_n, !out_valid, !in_stall)

    // a clamp leaves at least one component on a bound
    `QVR_ASSERT_NOW(a_sat_on_bound, clk, rst_n, out_valid && saturated, out_x == VEC_MAX || out_x == VEC_MIN || out_y == VEC_MAX || out_y == VEC_MIN || out_z == VEC_MAX || out_z == VEC_MIN)

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .saturated (saturated)
);
